FILE: sv/pi_controller_antiwindup_top_assert.svh
// Assertion macros for the PI controller block.
// Define ASSERT_OFF to compile them out.
`ifndef PI_CONTROLLER_ANTIWINDUP_TOP_ASSERT_SVH
`define PI_CONTROLLER_ANTIWINDUP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pi controller: assertion failed");

// cond must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("pi controller: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: sv/pica_pkg.sv
`default_nettype none

package pica_pkg;

    // data path width of error, drive and limits (signed Q1.(DATA_WIDTH-1))
    localparam int DATA_WIDTH = 16;

    localparam int KP_W      = 16;   // unsigned Q8.8
    localparam int KI_W      = 16;   // unsigned integer
    localparam int DT_W      = 24;   // unsigned Q0.24
    localparam int KD_W      = KI_W + DT_W;
    localparam int GAIN_FRAC = 8;
    localparam int INT_W     = 32;   // integrator

    // shared multiplier operands: A holds up to DT_W unsigned bits, B the error or ki
    localparam int MUL_A_W = DT_W + 1;
    localparam int MUL_B_W = (DATA_WIDTH > KI_W ? DATA_WIDTH : KI_W) + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // intermediate widths
    localparam int P_W     = DATA_WIDTH + KP_W - GAIN_FRAC;    // floor(e*kp/2^8)
    localparam int LO_W    = DATA_WIDTH;                       // floor(e*kd_lo/2^24)
    localparam int HI_W    = DATA_WIDTH + KD_W - DT_W;         // e*kd_hi
    localparam int INC_W   = HI_W + 1;
    localparam int CANDS_W = (INC_W > INT_W ? INC_W : INT_W) + 1;
    localparam int SUM_W   = (P_W > INT_W ? P_W : INT_W) + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (DT_W > DATA_WIDTH ? DT_W : DATA_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INT_GAIN       = 3'd1,
        REG_SAMPLE_PERIOD  = 3'd2,
        REG_OUT_LOW_LIMIT  = 3'd3,
        REG_OUT_HIGH_LIMIT = 3'd4
    } cfg_reg_t;

    localparam logic [KP_W-1:0] KP_RESET = KP_W'(512);
    localparam logic [KI_W-1:0] KI_RESET = KI_W'(200);
    localparam logic [DT_W-1:0] DT_RESET = DT_W'(1678);
    localparam logic [DATA_WIDTH-1:0] LOW_RESET  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] HIGH_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    // one multiply request to the shared unit
    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

`default_nettype wire

FILE: sv/pi_controller_antiwindup_top.sv
// Channel   | Direction | Ports                                    | Transaction
// ----------+-----------+------------------------------------------+--------------------------
// input     | in        | s_valid, s_ready, s_error_value          | one control error
// result    | out       | m_valid, m_ready, m_drive_value, m_clamped | one clamped drive value
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// An input transaction is taken in IDLE, then the sequencer steps run on one
// shared multiplier (ki*dt, e*kp, e*kd low, e*kd high), followed by the integrate and clamp steps.
// A new item is taken only after the sequencer is back in IDLE; the multiplier is the bottleneck.
// The result register lets IDLE accept the next item while a result still waits;
// the clamp step holds only if the previous result is still not taken.
// aresetn is synchronous, active low: config returns to defaults, integrator to zero.
`default_nettype none

`include "pi_controller_antiwindup_top_assert.svh"

module pi_controller_antiwindup_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [pica_pkg::DATA_WIDTH-1:0] s_error_value,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [pica_pkg::DATA_WIDTH-1:0]    m_drive_value,
    output logic                                      m_clamped,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pica_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pica_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DW = pica_pkg::DATA_WIDTH;

    // sequencer, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_KD   = 7'b0000010,   // ki * dt
        ST_PROP = 7'b0000100,   // e * kp, latch kd
        ST_LO   = 7'b0001000,   // e * kd[23:0], latch P
        ST_HI   = 7'b0010000,   // e * kd[39:24], latch low partial
        ST_SUM  = 7'b0100000,   // candidate integral with saturation
        ST_DONE = 7'b1000000    // clamp, anti-windup, load result
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic        [pica_pkg::KP_W-1:0] prop_gain_reg;
    logic        [pica_pkg::KI_W-1:0] int_gain_reg;
    logic        [pica_pkg::DT_W-1:0] sample_period_reg;
    logic signed [DW-1:0]             out_low_limit_reg;
    logic signed [DW-1:0]             out_high_limit_reg;

    // controller state
    logic signed [pica_pkg::INT_W-1:0] integral_reg, integral_next;

    // datapath
    logic signed [DW-1:0]                e_reg, e_next;
    logic        [pica_pkg::KD_W-1:0]    kd_reg, kd_next;
    logic signed [pica_pkg::P_W-1:0]     p_reg, p_next;
    logic signed [pica_pkg::LO_W-1:0]    lo_reg, lo_next;
    logic signed [pica_pkg::INT_W-1:0]   cand_reg, cand_next;

    logic signed [DW-1:0] m_drive_value_reg, m_drive_value_next;
    logic                 m_clamped_reg, m_clamped_next;
    logic                 m_valid_reg, m_valid_next;

    pica_pkg::mul_req_t             mul_req;
    logic [pica_pkg::MUL_P_W-1:0]   mul_product;

    logic signed [pica_pkg::HI_W-1:0]    hi_part;
    logic signed [pica_pkg::INC_W-1:0]   inc;
    logic signed [pica_pkg::CANDS_W-1:0] cand_sum;
    logic [pica_pkg::CANDS_W-pica_pkg::INT_W:0] cand_top;
    logic signed [pica_pkg::SUM_W-1:0]   out_sum;
    logic signed [pica_pkg::SUM_W-1:0]   high_ext;
    logic signed [pica_pkg::SUM_W-1:0]   low_ext;
    logic                                out_free;

    pica_mul u_mul (
        .aclk    (aclk),
        .req     (mul_req),
        .product (mul_product)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // operand select for the shared multiplier
    always_comb begin
        mul_req    = '0;
        mul_req.en = 1'b0;
        case (state_reg)
            ST_KD: begin
                mul_req.en = 1'b1;
                mul_req.a  = pica_pkg::MUL_A_W'(sample_period_reg);
                mul_req.b  = pica_pkg::MUL_B_W'(int_gain_reg);
            end
            ST_PROP: begin
                mul_req.en = 1'b1;
                mul_req.a  = pica_pkg::MUL_A_W'(prop_gain_reg);
                mul_req.b  = pica_pkg::MUL_B_W'(e_reg);
            end
            ST_LO: begin
                mul_req.en = 1'b1;
                mul_req.a  = pica_pkg::MUL_A_W'(kd_reg[pica_pkg::DT_W-1:0]);
                mul_req.b  = pica_pkg::MUL_B_W'(e_reg);
            end
            ST_HI: begin
                mul_req.en = 1'b1;
                mul_req.a  = pica_pkg::MUL_A_W'(kd_reg[pica_pkg::KD_W-1:pica_pkg::DT_W]);
                mul_req.b  = pica_pkg::MUL_B_W'(e_reg);
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // increment = e*kd_hi + floor(e*kd_lo / 2^24); floor of the full product
    always_comb begin
        hi_part  = mul_product[pica_pkg::HI_W-1:0];
        inc      = pica_pkg::INC_W'(hi_part) + pica_pkg::INC_W'(lo_reg);
        cand_sum = pica_pkg::CANDS_W'(integral_reg) + pica_pkg::CANDS_W'(inc);
        cand_top = cand_sum[pica_pkg::CANDS_W-1:pica_pkg::INT_W-1];
    end

    always_comb begin
        out_sum  = pica_pkg::SUM_W'(p_reg) + pica_pkg::SUM_W'(cand_reg);
        high_ext = pica_pkg::SUM_W'(out_high_limit_reg);
        low_ext  = pica_pkg::SUM_W'(out_low_limit_reg);
    end

    always_comb begin
        state_next         = state_reg;
        e_next             = e_reg;
        kd_next            = kd_reg;
        p_next             = p_reg;
        lo_next            = lo_reg;
        cand_next          = cand_reg;
        integral_next      = integral_reg;
        m_drive_value_next = m_drive_value_reg;
        m_clamped_next     = m_clamped_reg;
        m_valid_next       = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    e_next     = s_error_value;
                    state_next = ST_KD;
                end
            end
            ST_KD: begin
                state_next = ST_PROP;
            end
            ST_PROP: begin
                kd_next    = mul_product[pica_pkg::KD_W-1:0];
                state_next = ST_LO;
            end
            ST_LO: begin
                // arithmetic shift: floor
                p_next     = mul_product[DW+pica_pkg::KP_W-1:pica_pkg::GAIN_FRAC];
                state_next = ST_HI;
            end
            ST_HI: begin
                lo_next    = mul_product[DW+pica_pkg::DT_W-1:pica_pkg::DT_W];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // saturate to 32-bit two's complement
                if ((&cand_top) || !(|cand_top)) begin
                    cand_next = cand_sum[pica_pkg::INT_W-1:0];
                end else if (cand_sum[pica_pkg::CANDS_W-1]) begin
                    cand_next = pica_pkg::INT_MIN;
                end else begin
                    cand_next = pica_pkg::INT_MAX;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    // high limit checked first; inverted limits give high above it, else low
                    if (out_sum > high_ext) begin
                        m_drive_value_next = out_high_limit_reg;
                        m_clamped_next     = 1'b1;
                        if (e_reg < 0) begin
                            integral_next = cand_reg;
                        end
                    end else if (out_sum < low_ext) begin
                        m_drive_value_next = out_low_limit_reg;
                        m_clamped_next     = 1'b1;
                        if (e_reg > 0) begin
                            integral_next = cand_reg;
                        end
                    end else begin
                        m_drive_value_next = out_sum[DW-1:0];
                        m_clamped_next     = 1'b0;
                        integral_next      = cand_reg;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            integral_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            integral_reg <= integral_next;
        end
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg      <= pica_pkg::KP_RESET;
            int_gain_reg       <= pica_pkg::KI_RESET;
            sample_period_reg  <= pica_pkg::DT_RESET;
            out_low_limit_reg  <= pica_pkg::LOW_RESET;
            out_high_limit_reg <= pica_pkg::HIGH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pica_pkg::REG_PROP_GAIN: begin
                    prop_gain_reg <= cfg_data[pica_pkg::KP_W-1:0];
                end
                pica_pkg::REG_INT_GAIN: begin
                    int_gain_reg <= cfg_data[pica_pkg::KI_W-1:0];
                end
                pica_pkg::REG_SAMPLE_PERIOD: begin
                    sample_period_reg <= cfg_data[pica_pkg::DT_W-1:0];
                end
                pica_pkg::REG_OUT_LOW_LIMIT: begin
                    out_low_limit_reg <= cfg_data[DW-1:0];
                end
                pica_pkg::REG_OUT_HIGH_LIMIT: begin
                    out_high_limit_reg <= cfg_data[DW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        e_reg             <= e_next;
        kd_reg            <= kd_next;
        p_reg             <= p_next;
        lo_reg            <= lo_next;
        cand_reg          <= cand_next;
        m_drive_value_reg <= m_drive_value_next;
        m_clamped_reg     <= m_clamped_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_value_reg;
    assign m_clamped     = m_clamped_reg;

    // integrator moves only on the clamp step
    `ASSERT_CLK(a_int_update, aclk, aresetn, !$stable(integral_reg) |-> $past(state_reg == ST_DONE))
    // a new result appears only out of the clamp step
    `ASSERT_CLK(a_result_src, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
    // a clamped result sits on one of the limits
    `ASSERT_CLK(a_clamp_val, aclk, aresetn, (m_valid_reg && m_clamped_reg) |-> ((m_drive_value_reg == out_low_limit_reg) || (m_drive_value_reg == out_high_limit_reg)))
    // an unclamped result lies inside the limits
    `ASSERT_NEVER(a_in_range, aclk, aresetn, m_valid_reg && !m_clamped_reg && ((m_drive_value_reg > out_high_limit_reg) || (m_drive_value_reg < out_low_limit_reg)))

endmodule

`default_nettype wire

FILE: sv/pica_mul.sv
`default_nettype none

// Shared signed multiplier, product registered.
module pica_mul (
    input  wire logic                        aclk,
    input  wire pica_pkg::mul_req_t          req,
    output logic [pica_pkg::MUL_P_W-1:0]     product
);

    logic signed [pica_pkg::MUL_P_W-1:0] product_reg;
    logic signed [pica_pkg::MUL_P_W-1:0] product_next;

    always_comb begin
        product_next = pica_pkg::MUL_P_W'($signed(req.a))
                     * pica_pkg::MUL_P_W'($signed(req.b));
    end

    always_ff @(posedge aclk) begin
        if (req.en) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire
